// File: sv/clws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types and constants of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] OP_CMD   = 3'd0;
	localparam logic [2:0] OP_CHAR  = 3'd1;
	localparam logic [2:0] OP_MOVE  = 3'd2;
	localparam logic [2:0] OP_NUM   = 3'd3;
	localparam logic [2:0] OP_SHIFT = 3'd4;
	localparam logic [2:0] OP_CLEAR = 3'd5;
	localparam logic [2:0] OP_INIT  = 3'd6;

	localparam logic REG_FOUR_BIT  = 1'b0;
	localparam logic REG_DISP_CTRL = 1'b1;

	localparam logic       FOUR_BIT_RESET  = 1'b1;
	localparam logic [7:0] DISP_CTRL_RESET = 8'h0C;

	localparam logic [7:0] FUNC_SET_8  = 8'h38;
	localparam logic [7:0] FUNC_SET_4  = 8'h28;
	localparam logic [7:0] RETURN_HOME = 8'h02;
	localparam logic [7:0] CLEAR_CMD   = 8'h01;
	localparam logic [7:0] DDRAM_SET   = 8'h80;
	localparam logic [7:0] SHIFT_BASE  = 8'h10;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_MINUS    = 8'h2D;

	localparam logic [5:0] INIT_PAUSE_MS = 6'd35;
	localparam logic [1:0] EN_SHORT_MS   = 2'd1;
	localparam logic [1:0] EN_LONG_MS    = 2'd2;

	// one byte for the bus
	typedef struct packed {
		logic       rs;
		logic [7:0] data;
		logic       pre;
		logic       last;
		logic       tail;
	} clws_req_t;

endpackage

// File: sv/clws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_front
// Accepts operations and breaks them into byte requests; converts numbers
// to decimal with a bit-serial shift-add-3 pass.
// ----------------------------------------------------------------------------
module clws_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          operation,
	input  logic [7:0]          byte_value,
	input  logic                row,
	input  logic [5:0]          column,
	input  logic signed [31:0]  number,
	input  logic [1:0]          shift_direction,
	input  logic                four_bit,
	input  logic [7:0]          disp_ctrl,
	output logic                push_valid,
	input  logic                push_ready,
	output clws_pkg::clws_req_t push_req
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SINGLE = 3'd1;
	localparam logic [2:0] S_CONV   = 3'd2;
	localparam logic [2:0] S_SIGN   = 3'd3;
	localparam logic [2:0] S_DIG    = 3'd4;
	localparam logic [2:0] S_INIT   = 3'd5;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        started_q;
	logic [1:0]  step_q;
	logic [7:0]  byte_q;
	logic        rs_q;
	logic        tail_q;
	logic        neg_q;
	logic [31:0] bin_q;
	logic [39:0] bcd_q;

	logic [31:0] mag;
	logic [39:0] bcd_adj;
	logic        dig_push;
	logic [1:0]  init_final;
	logic [7:0]  init_byte;

	function automatic logic [39:0] dabble_adjust(input logic [39:0] v);
		logic [39:0] r;
		r = v;
		for (int i = 0; i < 10; i++) begin
			if (v[i*4 +: 4] >= 4'd5)
				r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
		end
		return r;
	endfunction

	assign mag        = number[31] ? (32'd0 - unsigned'(number)) : unsigned'(number);
	assign bcd_adj    = dabble_adjust(bcd_q);
	assign dig_push   = started_q || (bcd_q[39:36] != 4'd0);
	assign init_final = four_bit ? 2'd3 : 2'd2;
	assign in_ready   = (state_q == S_IDLE);

	always_comb begin
		init_byte = clws_pkg::CLEAR_CMD;
		if (four_bit) begin
			case (step_q)
				2'd0:    init_byte = clws_pkg::RETURN_HOME;
				2'd1:    init_byte = clws_pkg::FUNC_SET_4;
				2'd2:    init_byte = disp_ctrl;
				default: init_byte = clws_pkg::CLEAR_CMD;
			endcase
		end else begin
			case (step_q)
				2'd0:    init_byte = clws_pkg::FUNC_SET_8;
				2'd1:    init_byte = disp_ctrl;
				default: init_byte = clws_pkg::CLEAR_CMD;
			endcase
		end
	end

	always_comb begin
		push_valid    = 1'b0;
		push_req.rs   = rs_q;
		push_req.data = byte_q;
		push_req.pre  = 1'b0;
		push_req.last = 1'b0;
		push_req.tail = 1'b0;
		case (state_q)
			S_SINGLE: begin
				push_valid    = 1'b1;
				push_req.last = 1'b1;
				push_req.tail = tail_q;
			end
			S_SIGN: begin
				push_valid    = 1'b1;
				push_req.rs   = 1'b1;
				push_req.data = clws_pkg::CH_MINUS;
			end
			S_DIG: begin
				push_valid    = dig_push;
				push_req.rs   = 1'b1;
				push_req.data = clws_pkg::CH_ZERO | {4'd0, bcd_q[39:36]};
				push_req.last = (idx_q == 4'd9);
			end
			S_INIT: begin
				push_valid    = 1'b1;
				push_req.rs   = 1'b0;
				push_req.data = init_byte;
				push_req.pre  = (step_q == 2'd0);
				push_req.last = (step_q == init_final);
				push_req.tail = (step_q == init_final) && four_bit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= 5'd0;
			idx_q     <= 4'd0;
			started_q <= 1'b0;
			step_q    <= 2'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (operation)
							clws_pkg::OP_CMD, clws_pkg::OP_CHAR, clws_pkg::OP_MOVE,
							clws_pkg::OP_SHIFT, clws_pkg::OP_CLEAR:
								state_q <= S_SINGLE;
							clws_pkg::OP_NUM: begin
								cnt_q   <= 5'd0;
								state_q <= (mag == 32'd0) ? S_SINGLE : S_CONV;
							end
							clws_pkg::OP_INIT: begin
								step_q  <= 2'd0;
								state_q <= S_INIT;
							end
							default: ;
						endcase
					end
				end
				S_SINGLE: begin
					if (push_ready)
						state_q <= S_IDLE;
				end
				S_CONV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						idx_q     <= 4'd0;
						started_q <= 1'b0;
						state_q   <= neg_q ? S_SIGN : S_DIG;
					end
				end
				S_SIGN: begin
					if (push_ready)
						state_q <= S_DIG;
				end
				S_DIG: begin
					if (!dig_push || push_ready) begin
						started_q <= started_q | dig_push;
						idx_q     <= idx_q + 4'd1;
						if (idx_q == 4'd9)
							state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					if (push_ready) begin
						step_q <= step_q + 2'd1;
						if (step_q == init_final)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tail_q <= 1'b0;
				rs_q   <= 1'b0;
				neg_q  <= number[31];
				bin_q  <= mag;
				bcd_q  <= 40'd0;
				case (operation)
					clws_pkg::OP_CMD:   byte_q <= byte_value;
					clws_pkg::OP_CHAR: begin
						byte_q <= byte_value;
						rs_q   <= 1'b1;
					end
					clws_pkg::OP_MOVE:
						byte_q <= ({2'b00, column} + {1'b0, row, 6'd0}) | clws_pkg::DDRAM_SET;
					clws_pkg::OP_NUM: begin
						byte_q <= clws_pkg::CH_ZERO;
						rs_q   <= 1'b1;
					end
					clws_pkg::OP_SHIFT:
						byte_q <= clws_pkg::SHIFT_BASE | {4'd0, shift_direction, 2'b00};
					clws_pkg::OP_CLEAR: begin
						byte_q <= clws_pkg::CLEAR_CMD;
						tail_q <= four_bit;
					end
					default: byte_q <= byte_value;
				endcase
			end
			S_CONV: begin
				bcd_q <= {bcd_adj[38:0], bin_q[31]};
				bin_q <= {bin_q[30:0], 1'b0};
			end
			S_DIG: begin
				if (!dig_push || push_ready)
					bcd_q <= {bcd_q[35:0], 4'd0};
			end
			default: ;
		endcase
	end

endmodule

// File: sv/clws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_queue
// Small request queue between the front and the bus sequencer.
// ----------------------------------------------------------------------------
module clws_queue #(
	parameter int DEPTH = clws_pkg::QUEUE_DEPTH  // power of two, 2 or more
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  clws_pkg::clws_req_t push_req,
	output logic                pop_valid,
	input  logic                pop_ready,
	output clws_pkg::clws_req_t pop_req
);

	localparam int AW = $clog2(DEPTH);

	clws_pkg::clws_req_t mem_q [DEPTH];
	logic [AW:0] wr_ptr_q;
	logic [AW:0] rd_ptr_q;

	assign pop_valid  = (wr_ptr_q != rd_ptr_q);
	assign push_ready = !((wr_ptr_q[AW] != rd_ptr_q[AW]) &&
	                      (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]));
	assign pop_req    = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && push_ready)
				wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
			if (pop_valid && pop_ready)
				rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready)
			mem_q[wr_ptr_q[AW-1:0]] <= push_req;
	end

endmodule

// File: sv/clws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_back
// Turns byte requests into enable strobes, one or two nibbles per byte,
// through a registered output stage.
// ----------------------------------------------------------------------------
module clws_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                four_bit,
	input  logic                req_valid,
	output logic                req_ready,
	input  clws_pkg::clws_req_t req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                register_select,
	output logic [7:0]          bus_value,
	output logic [1:0]          enable_high_ms,
	output logic [5:0]          pause_before_ms,
	output logic                pause_after_ms,
	output logic                last
);

	clws_pkg::clws_req_t cur_q;
	logic busy_q;
	logic phase_q;
	logic out_valid_q;
	logic fire;
	logic high_nib;

	assign req_ready = !busy_q;
	assign fire      = busy_q && (!out_valid_q || out_ready);
	assign high_nib  = four_bit && !phase_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (req_valid && req_ready) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (fire) begin
				if (high_nib)
					phase_q <= 1'b1;
				else
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			cur_q <= req;
		if (fire) begin
			register_select <= cur_q.rs;
			if (!four_bit)
				bus_value <= cur_q.data;
			else if (!phase_q)
				bus_value <= {4'd0, cur_q.data[7:4]};
			else
				bus_value <= {4'd0, cur_q.data[3:0]};
			enable_high_ms  <= high_nib ? clws_pkg::EN_SHORT_MS : clws_pkg::EN_LONG_MS;
			pause_before_ms <= (cur_q.pre && !phase_q) ? clws_pkg::INIT_PAUSE_MS : 6'd0;
			pause_after_ms  <= !high_nib && cur_q.tail;
			last            <= !high_nib && cur_q.last;
		end
	end

endmodule

// File: sv/char_lcd_write_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_core
// Character LCD write sequencer: operations in, enable strobes out.
// ----------------------------------------------------------------------------
// One operation is taken at a time. A command, character, cursor move, shift
// or clear, or a zero number, is a single byte in the front; init issues its
// bytes in turn. A nonzero number passes through the bit-serial decimal
// conversion, a sign step if negative and ten digit steps. The bus side
// issues one strobe per cycle within a byte while out_ready holds, and takes
// a new byte only once the last is done, following the front via the queue.
module char_lcd_write_sequencer_core #(
	parameter int QUEUE_DEPTH = clws_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [7:0]         byte_value,
	input  logic               row,
	input  logic [5:0]         column,
	input  logic signed [31:0] number,
	input  logic [1:0]         shift_direction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               register_select,
	output logic [7:0]         bus_value,
	output logic [1:0]         enable_high_ms,
	output logic [5:0]         pause_before_ms,
	output logic               pause_after_ms,
	output logic               last
);

	logic       four_bit_q;
	logic [7:0] disp_ctrl_q;

	logic                push_valid;
	logic                push_ready;
	clws_pkg::clws_req_t push_req;
	logic                pop_valid;
	logic                pop_ready;
	clws_pkg::clws_req_t pop_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q  <= clws_pkg::FOUR_BIT_RESET;
			disp_ctrl_q <= clws_pkg::DISP_CTRL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				clws_pkg::REG_FOUR_BIT:  four_bit_q  <= cfg_data[0];
				clws_pkg::REG_DISP_CTRL: disp_ctrl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	clws_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.byte_value      (byte_value),
		.row             (row),
		.column          (column),
		.number          (number),
		.shift_direction (shift_direction),
		.four_bit        (four_bit_q),
		.disp_ctrl       (disp_ctrl_q),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_req        (push_req)
	);

	clws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req)
	);

	clws_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.four_bit        (four_bit_q),
		.req_valid       (pop_valid),
		.req_ready       (pop_ready),
		.req             (pop_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.register_select (register_select),
		.bus_value       (bus_value),
		.enable_high_ms  (enable_high_ms),
		.pause_before_ms (pause_before_ms),
		.pause_after_ms  (pause_after_ms),
		.last            (last)
	);

endmodule

// File: sv/clws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_checker
// Port-level checks on the strobe request stream.
// ----------------------------------------------------------------------------
module clws_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       register_select,
	input logic [7:0] bus_value,
	input logic [1:0] enable_high_ms,
	input logic [5:0] pause_before_ms,
	input logic       pause_after_ms,
	input logic       last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bus_value) && $stable(last))
		else $error("stalled strobe request changed");

	a_high_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (enable_high_ms == 2'd1) |-> !last && !pause_after_ms &&
			(bus_value[7:4] == 4'd0))
		else $error("high nibble strobe ends operation or is too wide");

	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pause_after_ms |-> last && !register_select &&
			(enable_high_ms == 2'd2))
		else $error("pause after a strobe that is not the final one");

	a_init_pause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pause_before_ms != 6'd0) |-> (pause_before_ms == 6'd35) &&
			!register_select && !last)
		else $error("bad pause before strobe");

endmodule

bind char_lcd_write_sequencer_core clws_checker u_clws_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.register_select (register_select),
	.bus_value       (bus_value),
	.enable_high_ms  (enable_high_ms),
	.pause_before_ms (pause_before_ms),
	.pause_after_ms  (pause_after_ms),
	.last            (last)
);
